[rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

   // Operation codes
   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_DEQUEUE = 2'd1;
   localparam logic [1:0] OP_PEEK    = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] item_value;
      logic [7:0]         item_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] front_value;
      logic [7:0]         front_priority;
      logic [1:0]         status;
      logic [4:0]         occupancy;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [7:0]         prio;
   } entry_type;

   // Shift command broadcast to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type item;
   } cell_cmd_type;

endpackage

`default_nettype wire

[rtl/spq_cell.sv]
`default_nettype none

module spq_cell (
   input  wire logic                clock,
   input  wire spq_pkg::cell_cmd_type cmd,
   input  wire spq_pkg::entry_type  left_entry,
   input  wire logic                left_keep,
   input  wire spq_pkg::entry_type  right_entry,
   input  wire logic                occupied,
   output logic                     keep,
   output spq_pkg::entry_type       entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // Hold when this entry ranks at or above the new item.
   assign keep = occupied && (entry_ff.prio >= cmd.item.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.enq) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in = cmd.item;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[rtl/sorted_priority_queue.sv]
`default_nettype none

// Sorted priority queue built as a row of QUEUE_DEPTH cells.
//
// Input channel: a beat (req_data: operation, item_value, item_priority) is taken
// at a rising edge where start is high and busy is low. Enqueue inserts the item
// behind every held entry of equal or higher priority; dequeue pops the front;
// peek reads the front in place.
// Result channel: every accepted beat produces exactly one result beat on
// rsp_data, marked by rsp_strobe for one cycle, in the cycle after acceptance.
// The receiver cannot stall; results are never held back.
// Throughput: one beat per cycle while busy is low. Each cell compares its own
// priority with the incoming one and either holds, takes the new item, or takes
// its neighbor's entry, so an insert or a pop shifts the whole row together.
// Reset: the entry count clears, busy is high for the cycle after reset, and the
// entry contents stay as they were (only entries below the count are read).
// Full enqueues are dropped with status full; empty dequeue/peek report empty.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire spq_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output spq_pkg::rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                 busy_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_strobe_ff;
   spq_pkg::rsp_type     rsp_ff;
   spq_pkg::rsp_type     rsp_in;

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   spq_pkg::cell_cmd_type cmd;

   spq_pkg::entry_type   cell_entry [QUEUE_DEPTH];
   logic                 cell_keep  [QUEUE_DEPTH];

   assign accept   = start && !busy_ff;
   assign is_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // Broadcast command: shift only on an insert into room, or a pop with data.
   assign cmd.enq        = accept && (req_data.operation == spq_pkg::OP_ENQUEUE) && !is_full;
   assign cmd.deq        = accept && (req_data.operation == spq_pkg::OP_DEQUEUE) && !is_empty;
   assign cmd.item.value = req_data.item_value;
   assign cmd.item.prio  = req_data.item_priority;

   // Row of cells; cell 0 is the front. The head cell sees a left neighbor
   // that always keeps, so it loads the new item when it gives way. The tail
   // cell pulls in don't-care data on a pop (it lies beyond the count).
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_pkg::entry_type left_entry;
      spq_pkg::entry_type right_entry;
      logic               left_keep;

      if (i == 0) begin : g_head
         assign left_entry = cmd.item;
         assign left_keep  = 1'b1;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_keep  = cell_keep[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_entry = cmd.item;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .left_entry  (left_entry),
         .left_keep   (left_keep),
         .right_entry (right_entry),
         .occupied    (CNT_W'(i) < count_ff),
         .keep        (cell_keep[i]),
         .entry       (cell_entry[i])
      );
   end

   // Next count and result beat
   always_comb begin
      count_in = count_ff;
      if (cmd.enq) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.deq) begin
         count_in = count_ff - CNT_W'(1);
      end

      rsp_in.front_value    = '0;
      rsp_in.front_priority = '0;
      rsp_in.status         = spq_pkg::STATUS_OK;
      case (req_data.operation)
         spq_pkg::OP_ENQUEUE: begin
            if (is_full) begin
               rsp_in.status = spq_pkg::STATUS_FULL;
            end
         end
         spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
            if (is_empty) begin
               rsp_in.status = spq_pkg::STATUS_EMPTY;
            end else begin
               rsp_in.front_value    = cell_entry[0].value;
               rsp_in.front_priority = cell_entry[0].prio;
            end
         end
         default: begin
            rsp_in.status = spq_pkg::STATUS_OK;
         end
      endcase
      // Occupancy reports the count modulo 32.
      rsp_in.occupancy = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Assertions
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("accepted beat produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result without an accepted beat");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds depth");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.deq |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not decrement count");

   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CNT_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
      else $error("front entries out of priority order");

   a_full_occupancy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == spq_pkg::STATUS_FULL))
         |-> (rsp_data.occupancy == 5'(QUEUE_DEPTH)))
      else $error("full status with wrong occupancy");

endmodule

`default_nettype wire
